@@ hw/rtl/sshm_pkg.sv @@
// Shared types and constants for the sensor stamp health monitor.
package sshm_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 48;

  localparam logic [CFG_INDEX_W-1:0] CFG_DROPOUT_GAP = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_FAILED_GAP  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_BAND_ENABLE = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_RATE_LOW    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_RATE_HIGH   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_SOURCE      = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_SKEW_LIMIT  = 3'd6;

  localparam logic [2:0] FB_SYNC = 3'd0;
  localparam logic [2:0] FB_STEP = 3'd1;
  localparam logic [2:0] FB_SKEW = 3'd2;
  localparam logic [2:0] FB_DROP = 3'd3;
  localparam logic [2:0] FB_LOW  = 3'd4;
  localparam logic [2:0] FB_HIGH = 3'd5;

  localparam logic [2:0] SRC_SOFTWARE = 3'd0;
  localparam logic [2:0] SRC_ARRIVAL  = 3'd1;

  localparam logic [1:0] LVL_NOMINAL  = 2'd0;
  localparam logic [1:0] LVL_DEGRADED = 2'd1;
  localparam logic [1:0] LVL_FAILED   = 2'd2;

  // 1e9 ns per second in Q48.16
  localparam logic [63:0] RATE_NUM = 64'd65536000000000;

  localparam int DIV_STEPS = 32;
  localparam int D10_STEPS = 5;

  typedef struct packed {
    logic [62:0]        stamp_ns;
    logic [2:0]         stamp_source;
    logic signed [31:0] skew_q8;
    logic               skew_valid;
  } in_word_t;

  typedef struct packed {
    logic [62:0] stamp_out;
    logic        clamped;
    logic [5:0]  fault_bits;
    logic [5:0]  new_faults;
    logic [2:0]  dominant_fault;
    logic [1:0]  health_level;
    logic [62:0] level_since_ns;
    logic [31:0] rate_estimate;
  } out_word_t;

  typedef struct packed {
    logic load;
    logic div_init;
    logic div_step;
    logic d10_init;
    logic d10_step;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic need_div;
    logic rate_zero;
  } stat_t;

endpackage

@@ hw/rtl/sshm_ctrl.sv @@
// Sequencing state machine for the sensor stamp health monitor.
module sshm_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  sshm_pkg::stat_t stat,
  output sshm_pkg::cmd_t  cmd
);
  import sshm_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_PREP, S_DIV, S_MIX, S_D10, S_FIN} state_t;

  state_t     state;
  logic [4:0] cnt;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd.load     = (state == S_IDLE) && in_valid;
    cmd.div_init = (state == S_PREP) && stat.need_div;
    cmd.div_step = (state == S_DIV);
    cmd.d10_init = (state == S_MIX) && !stat.rate_zero;
    cmd.d10_step = (state == S_D10);
    cmd.commit   = (state == S_FIN) && (!out_valid || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_PREP;
          end
        end
        S_PREP: begin
          cnt <= '0;
          state <= stat.need_div ? S_DIV : S_FIN;
        end
        S_DIV: begin
          cnt <= cnt + 5'd1;
          if (cnt == 5'(DIV_STEPS - 1)) begin
            state <= S_MIX;
          end
        end
        S_MIX: begin
          cnt <= '0;
          state <= stat.rate_zero ? S_FIN : S_D10;
        end
        S_D10: begin
          cnt <= cnt + 5'd1;
          if (cnt == 5'(D10_STEPS - 1)) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (cmd.commit) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_accept_prep: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_PREP))
    else $error("accepted word did not start preparation");

  a_div_needed: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> stat.need_div)
    else $error("divider running without a gap");

  a_d10_rate: assert property (@(posedge clk) disable iff (rst)
    (state == S_D10) |-> !stat.rate_zero)
    else $error("smoothing step with zero rate");

  a_commit_out: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid)
    else $error("committed word not presented");

endmodule

@@ hw/rtl/sshm_datapath.sv @@
// Datapath of the sensor stamp health monitor: stamps, rate divider, fault logic.
module sshm_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [sshm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sshm_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  sshm_pkg::in_word_t               in_word,
  input  sshm_pkg::cmd_t                   cmd,
  output sshm_pkg::stat_t                  stat,
  output sshm_pkg::out_word_t              out_word
);
  import sshm_pkg::*;

  typedef struct packed {
    logic [5:0] f;
    logic       lg;
    logic [1:0] lvl;
    logic       moved;
  } hstate_t;

  function automatic logic [1:0] level_of(logic [5:0] f, logic lg);
    if (f == 6'd0) begin
      level_of = LVL_NOMINAL;
    end else if (f[FB_DROP] && lg) begin
      level_of = LVL_FAILED;
    end else begin
      level_of = LVL_DEGRADED;
    end
  endfunction

  function automatic hstate_t set_bit(hstate_t s, logic [2:0] idx, logic val);
    hstate_t    r;
    logic [1:0] l;
    r = s;
    if (s.f[idx] != val) begin
      r.f[idx] = val;
      l = level_of(r.f, r.lg);
      if (l != r.lvl) begin
        r.moved = 1'b1;
      end
      r.lvl = l;
    end
    return r;
  endfunction

  function automatic logic [11:0] div10_byte(logic [3:0] r_in, logic [7:0] b);
    logic [4:0] rr;
    logic [3:0] r;
    logic [7:0] q;
    r = r_in;
    q = '0;
    for (int k = 7; k >= 0; k--) begin
      rr = {r, b[k]};
      if (rr >= 5'd10) begin
        rr   = rr - 5'd10;
        q[k] = 1'b1;
      end
      r = rr[3:0];
    end
    return {q, r};
  endfunction

  logic [47:0] dropout_gap;
  logic [47:0] failed_gap;
  logic        band_en;
  logic [31:0] rate_low;
  logic [31:0] rate_high;
  logic [2:0]  cfg_source;
  logic [30:0] skew_limit;

  logic [62:0] last_stamp;
  logic        have_prev;
  logic [31:0] rate_value;
  logic [5:0]  active_faults;
  logic        long_gap;
  logic [1:0]  level;
  logic [62:0] level_start;

  logic [62:0] t_stamp;
  logic        clamped_r;
  logic [62:0] gap;
  logic [2:0]  src;
  logic        skew_valid_r;
  logic        skew_over;

  logic [63:0] rem;
  logic [31:0] num_lo;
  logic [31:0] quo;
  logic        sat;

  logic [39:0] x10;
  logic [3:0]  r10;
  logic [31:0] q10;

  out_word_t   out_r;

  logic        clamp_c;
  logic [32:0] skew_mag;
  logic [63:0] numer;
  logic [63:0] trial;
  logic        trial_ge;
  logic [11:0] d10_c;
  logic [36:0] mix_sum;
  logic [31:0] inst;
  logic [31:0] rate_new;
  hstate_t     chain;
  logic [2:0]  dom;

  assign stat.need_div  = have_prev && (gap != '0);
  assign stat.rate_zero = (rate_value == '0);
  assign out_word       = out_r;

  assign clamp_c  = in_word.stamp_ns < last_stamp;
  assign skew_mag = in_word.skew_q8[31] ? (33'h1_0000_0000 - {1'b0, in_word.skew_q8})
                                        : {1'b0, in_word.skew_q8};
  assign numer    = RATE_NUM + {1'b0, gap[62:1]};
  assign trial    = {rem[62:0], num_lo[31]};
  assign trial_ge = trial >= {1'b0, gap};
  assign d10_c    = div10_byte(r10, x10[39:32]);
  assign mix_sum  = {2'b0, rate_value, 3'b0} + {5'b0, rate_value} + {5'b0, inst} + 37'd5;
  assign inst     = sat ? '1 : quo;

  always_comb begin
    if (!stat.need_div) begin
      rate_new = rate_value;
    end else if (stat.rate_zero) begin
      rate_new = inst;
    end else begin
      rate_new = q10;
    end
  end

  always_comb begin
    chain.f     = active_faults;
    chain.lg    = long_gap;
    chain.lvl   = level;
    chain.moved = 1'b0;
    chain = set_bit(chain, FB_STEP, clamped_r);
    if (have_prev) begin
      if (gap > {15'd0, dropout_gap}) begin
        chain.lg = gap > {15'd0, failed_gap};
        chain = set_bit(chain, FB_DROP, 1'b1);
      end else begin
        chain.lg = 1'b0;
        chain = set_bit(chain, FB_DROP, 1'b0);
      end
      if (band_en && (rate_new != '0)) begin
        if (rate_new < rate_low) begin
          chain = set_bit(chain, FB_HIGH, 1'b0);
          chain = set_bit(chain, FB_LOW, 1'b1);
        end else if (rate_new > rate_high) begin
          chain = set_bit(chain, FB_LOW, 1'b0);
          chain = set_bit(chain, FB_HIGH, 1'b1);
        end else begin
          chain = set_bit(chain, FB_LOW, 1'b0);
          chain = set_bit(chain, FB_HIGH, 1'b0);
        end
      end
    end
    if ((src == SRC_SOFTWARE) && (cfg_source != SRC_SOFTWARE) &&
        (cfg_source != SRC_ARRIVAL)) begin
      chain = set_bit(chain, FB_SYNC, 1'b1);
    end else if (src == cfg_source) begin
      chain = set_bit(chain, FB_SYNC, 1'b0);
    end
    if (skew_valid_r) begin
      chain = set_bit(chain, FB_SKEW, skew_over);
    end
    if (level_of(chain.f, chain.lg) != chain.lvl) begin
      chain.moved = 1'b1;
    end
    chain.lvl = level_of(chain.f, chain.lg);
  end

  always_comb begin
    dom = 3'd0;
    for (int i = 5; i >= 0; i--) begin
      if (chain.f[i]) begin
        dom = 3'(i + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dropout_gap <= 48'd100000000;
      failed_gap  <= 48'd1000000000;
      band_en     <= 1'b0;
      rate_low    <= '0;
      rate_high   <= '1;
      cfg_source  <= SRC_ARRIVAL;
      skew_limit  <= 31'd25600;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_DROPOUT_GAP: dropout_gap <= cfg_data;
        CFG_FAILED_GAP:  failed_gap  <= cfg_data;
        CFG_BAND_ENABLE: band_en     <= cfg_data[0];
        CFG_RATE_LOW:    rate_low    <= cfg_data[31:0];
        CFG_RATE_HIGH:   rate_high   <= cfg_data[31:0];
        CFG_SOURCE:      cfg_source  <= cfg_data[2:0];
        CFG_SKEW_LIMIT:  skew_limit  <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_stamp    <= '0;
      have_prev     <= 1'b0;
      rate_value    <= '0;
      active_faults <= '0;
      long_gap      <= 1'b0;
      level         <= LVL_NOMINAL;
      level_start   <= '0;
    end else begin
      if (cmd.load && !clamp_c) begin
        last_stamp <= in_word.stamp_ns;
      end
      if (cmd.commit) begin
        have_prev     <= 1'b1;
        rate_value    <= rate_new;
        active_faults <= chain.f;
        long_gap      <= chain.lg;
        level         <= chain.lvl;
        if (chain.moved) begin
          level_start <= t_stamp;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      t_stamp      <= clamp_c ? last_stamp : in_word.stamp_ns;
      clamped_r    <= clamp_c;
      gap          <= clamp_c ? '0 : (in_word.stamp_ns - last_stamp);
      src          <= in_word.stamp_source;
      skew_valid_r <= in_word.skew_valid;
      skew_over    <= skew_mag > {2'b0, skew_limit};
    end
    if (cmd.div_init) begin
      rem    <= {32'd0, numer[63:32]};
      num_lo <= numer[31:0];
      quo    <= '0;
      sat    <= {31'd0, numer[63:32]} >= gap;
    end else if (cmd.div_step) begin
      rem    <= trial_ge ? (trial - {1'b0, gap}) : trial;
      num_lo <= {num_lo[30:0], 1'b0};
      quo    <= {quo[30:0], trial_ge};
    end
    if (cmd.d10_init) begin
      x10 <= {3'd0, mix_sum};
      r10 <= '0;
      q10 <= '0;
    end else if (cmd.d10_step) begin
      x10 <= {x10[31:0], 8'd0};
      r10 <= d10_c[3:0];
      q10 <= {q10[23:0], d10_c[11:4]};
    end
    if (cmd.commit) begin
      out_r.stamp_out      <= t_stamp;
      out_r.clamped        <= clamped_r;
      out_r.fault_bits     <= chain.f;
      out_r.new_faults     <= chain.f & ~active_faults;
      out_r.dominant_fault <= dom;
      out_r.health_level   <= chain.lvl;
      out_r.level_since_ns <= chain.moved ? t_stamp : level_start;
      out_r.rate_estimate  <= rate_new;
    end
  end

  a_stamp_monotone: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (last_stamp >= $past(last_stamp)))
    else $error("last stamp went backward");

  a_failed_dropout: assert property (@(posedge clk) disable iff (rst)
    (level == LVL_FAILED) |-> (active_faults[FB_DROP] && long_gap))
    else $error("failed level without long dropout");

endmodule

@@ hw/rtl/sensor_stamp_health_monitor.sv @@
// Top level of the sensor stamp health monitor.
//
//   channel | signals                         | direction
//   --------+---------------------------------+----------
//   in      | in_valid, in_stall, in_word     | stamp word in
//   out     | out_valid, out_stall, out_word  | health word out
//   cfg     | cfg_write, cfg_index, cfg_data  | register write
//
// A word with a nonzero gap after the first runs the rate divider for 32 quotient
// bits, one bit per cycle, and then the divide-by-ten smoothing step, which is
// skipped when the stored rate is zero. The first word and a zero gap skip both.
// A new word is accepted only once the previous one is done. Reset is synchronous;
// the output register holds a finished word under out_stall while the next is accepted.
module sensor_stamp_health_monitor (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  sshm_pkg::in_word_t               in_word,
  output logic                             out_valid,
  input  logic                             out_stall,
  output sshm_pkg::out_word_t              out_word,
  input  logic                             cfg_write,
  input  logic [sshm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sshm_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import sshm_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  sshm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  sshm_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_word   (in_word),
    .cmd       (cmd),
    .stat      (stat),
    .out_word  (out_word)
  );

endmodule

@@ dv/sensor_stamp_health_monitor_tb.sv @@
// Self-checking testbench for the sensor stamp health monitor: predicted health words vs. the block.
module sensor_stamp_health_monitor_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sshm_pkg::*;

  localparam logic [63:0] NS_RATE_Q16 = 64'd65_536_000_000_000;
  localparam logic [63:0] MAX63 = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 3'd7;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE_CYCLES = 50;
  localparam int RANDOM_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 200;
  localparam int EDGE_ITEMS = 30;
  localparam int REPORT_CAP = 50;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_stall;
  in_word_t in_word;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_word;
  logic cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // register mirror
  logic [47:0] dropout_limit = 48'd100_000_000;
  logic [47:0] failed_limit = 48'd1_000_000_000;
  logic band_on = 1'b0;
  logic [31:0] band_low = 32'd0;
  logic [31:0] band_high = 32'hFFFF_FFFF;
  logic [2:0] expected_source = SRC_ARRIVAL;
  logic [30:0] skew_limit = 31'd25600;

  // monitor state
  logic [62:0] seen_stamp = '0;
  logic primed = 1'b0;
  logic [31:0] smoothed_rate = '0;
  logic [5:0] faults = '0;
  logic long_gap = 1'b0;
  logic [1:0] level = LVL_NOMINAL;
  logic [62:0] level_stamp = '0;

  out_word_t expected_health[$];

  int in_idle_pct = 10;
  int out_stall_pct = 10;
  int hold_span = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int cycle_count = 0;
  int mismatches = 0;
  int words_sent = 0;
  int words_checked = 0;
  int reg_writes = 0;
  int clamps = 0;
  int failed_levels = 0;

  sensor_stamp_health_monitor uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_word(in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word(out_word),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d words outstanding", $time, cycle_count,
               expected_health.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic void relevel(logic [62:0] t);
    logic [1:0] lvl;
    lvl = LVL_NOMINAL;
    if (faults != 6'd0) begin
      lvl = (faults[FB_DROP] && long_gap) ? LVL_FAILED : LVL_DEGRADED;
    end
    if (lvl != level) begin
      level_stamp = t;
    end
    level = lvl;
  endfunction

  function automatic void raise_fault(logic [2:0] b, logic [62:0] t);
    if (!faults[b]) begin
      faults[b] = 1'b1;
      relevel(t);
    end
  endfunction

  function automatic void clear_fault(logic [2:0] b, logic [62:0] t);
    if (faults[b]) begin
      faults[b] = 1'b0;
      relevel(t);
    end
  endfunction

  function automatic out_word_t predict_health(in_word_t w);
    out_word_t r;
    logic [5:0] prior;
    logic [62:0] t;
    logic [62:0] prev;
    logic [63:0] gap;
    logic [63:0] inst;
    logic [63:0] blend;
    logic [31:0] raw;
    logic [32:0] mag;
    r = '0;
    prior = faults;
    prev = seen_stamp;
    if (w.stamp_ns < seen_stamp) begin
      t = seen_stamp;
      r.clamped = 1'b1;
      raise_fault(FB_STEP, t);
    end else begin
      t = w.stamp_ns;
      clear_fault(FB_STEP, t);
      seen_stamp = w.stamp_ns;
    end
    if (primed) begin
      gap = {1'b0, t} - {1'b0, prev};
      if (gap != 64'd0) begin
        inst = (NS_RATE_Q16 + gap / 64'd2) / gap;
        if (inst > 64'hFFFF_FFFF) begin
          inst = 64'hFFFF_FFFF;
        end
        if (smoothed_rate != 32'd0) begin
          blend = (64'd9 * smoothed_rate + inst + 64'd5) / 64'd10;
          smoothed_rate = blend[31:0];
        end else begin
          smoothed_rate = inst[31:0];
        end
      end
      if (gap > dropout_limit) begin
        long_gap = gap > failed_limit;
        raise_fault(FB_DROP, t);
      end else begin
        long_gap = 1'b0;
        clear_fault(FB_DROP, t);
      end
      if (band_on && smoothed_rate != 32'd0) begin
        if (smoothed_rate < band_low) begin
          clear_fault(FB_HIGH, t);
          raise_fault(FB_LOW, t);
        end else if (smoothed_rate > band_high) begin
          clear_fault(FB_LOW, t);
          raise_fault(FB_HIGH, t);
        end else begin
          clear_fault(FB_LOW, t);
          clear_fault(FB_HIGH, t);
        end
      end
    end
    if (w.stamp_source == SRC_SOFTWARE && expected_source != SRC_SOFTWARE &&
        expected_source != SRC_ARRIVAL) begin
      raise_fault(FB_SYNC, t);
    end else if (w.stamp_source == expected_source) begin
      clear_fault(FB_SYNC, t);
    end
    if (w.skew_valid) begin
      raw = w.skew_q8;
      mag = raw[31] ? (33'h1_0000_0000 - {1'b0, raw}) : {1'b0, raw};
      if (mag > {2'b0, skew_limit}) begin
        raise_fault(FB_SKEW, t);
      end else begin
        clear_fault(FB_SKEW, t);
      end
    end
    primed = 1'b1;
    relevel(t);
    r.stamp_out = t;
    r.fault_bits = faults;
    r.new_faults = faults & ~prior;
    r.dominant_fault = 3'd0;
    for (int i = 5; i >= 0; i--) begin
      if (faults[i]) begin
        r.dominant_fault = 3'(i + 1);
      end
    end
    r.health_level = level;
    r.level_since_ns = level_stamp;
    r.rate_estimate = smoothed_rate;
    return r;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= REPORT_CAP) begin
        $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      end
    end
  endfunction

  always @(posedge clk) begin
    out_word_t want;
    if (!rst && out_valid && !out_stall) begin
      words_checked++;
      if (expected_health.size() == 0) begin
        mismatches++;
        $display("%0t: health word expected none actual %0h", $time, out_word);
      end else begin
        want = expected_health.pop_front();
        check_field("stamp_out", 64'(want.stamp_out), 64'(out_word.stamp_out));
        check_field("clamped", 64'(want.clamped), 64'(out_word.clamped));
        check_field("fault_bits", 64'(want.fault_bits), 64'(out_word.fault_bits));
        check_field("new_faults", 64'(want.new_faults), 64'(out_word.new_faults));
        check_field("dominant_fault", 64'(want.dominant_fault),
                    64'(out_word.dominant_fault));
        check_field("health_level", 64'(want.health_level), 64'(out_word.health_level));
        check_field("level_since_ns", 64'(want.level_since_ns),
                    64'(out_word.level_since_ns));
        check_field("rate_estimate", 64'(want.rate_estimate), 64'(out_word.rate_estimate));
      end
    end
  end

  always @(negedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left = hold_span;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < out_stall_pct);
    end
  end

  task automatic send_stamp(in_word_t w);
    out_word_t want;
    if ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < 50);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_stall);
    want = predict_health(w);
    expected_health.insert(expected_health.size(), want);
    words_sent++;
    if (want.clamped) clamps++;
    if (want.health_level == LVL_FAILED) failed_levels++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_health.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_register(logic [CFG_INDEX_W-1:0] idx, logic [47:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
    case (idx)
      CFG_DROPOUT_GAP: dropout_limit = value;
      CFG_FAILED_GAP: failed_limit = value;
      CFG_BAND_ENABLE: band_on = value[0];
      CFG_RATE_LOW: band_low = value[31:0];
      CFG_RATE_HIGH: band_high = value[31:0];
      CFG_SOURCE: expected_source = value[2:0];
      CFG_SKEW_LIMIT: skew_limit = value[30:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  function automatic in_word_t make_word(logic [63:0] stamp, logic [2:0] src,
                                         logic [31:0] skew, logic skew_ok);
    in_word_t w;
    w.stamp_ns = stamp[62:0];
    w.stamp_source = src;
    w.skew_q8 = skew;
    w.skew_valid = skew_ok;
    return w;
  endfunction

  function automatic in_word_t random_stamp(logic [63:0] nominal);
    logic [63:0] base;
    logic [63:0] gap;
    logic [63:0] sum;
    logic [63:0] back;
    logic [31:0] skew;
    logic [2:0] src;
    int pick;
    int src_pick;
    base = {1'b0, seen_stamp};
    pick = $urandom_range(99);
    if (pick < 68) begin
      gap = nominal - nominal / 8 + 64'($urandom_range(0, 32'(nominal / 4)));
    end else if (pick < 76) begin
      gap = 64'($urandom_range(0, 32'(nominal / 3)));
    end else if (pick < 83) begin
      gap = nominal * 64'($urandom_range(2, 5));
    end else if (pick < 87) begin
      gap = 64'(dropout_limit) + 64'($urandom_range(0, 2));
    end else if (pick < 91) begin
      gap = 64'(failed_limit) + 64'($urandom_range(0, 2)) +
            64'($urandom_range(0, 1) * $urandom_range(0, 5000));
    end else if (pick < 94) begin
      gap = 64'd0;
    end else if (pick < 98) begin
      gap = 64'd0;
      back = 64'($urandom_range(1, 32'(nominal)));
      base = (base > back) ? base - back : 64'd0;
    end else begin
      gap = 64'($urandom);
    end
    sum = base + gap;
    if (sum > MAX63) sum = MAX63;
    src_pick = $urandom_range(99);
    if (src_pick < 80) src = expected_source;
    else if (src_pick < 90) src = SRC_SOFTWARE;
    else src = 3'($urandom_range(7));
    if ($urandom_range(9) == 0) begin
      skew = $urandom;
    end else begin
      skew = $urandom_range(0, 32'({skew_limit, 1'b0}));
      if ($urandom_range(1)) skew = -skew;
    end
    return make_word(sum, src, skew, $urandom_range(99) < 75);
  endfunction

  task automatic test_directed_cases();
    logic [63:0] stamp;
    stamp = 64'd1000;
    send_stamp(make_word(stamp, SRC_ARRIVAL, 32'd0, 1'b1));
    send_stamp(make_word(stamp, SRC_ARRIVAL, 32'd0, 1'b1));
    stamp += 64'd1_000_000;
    send_stamp(make_word(stamp, SRC_ARRIVAL, 32'd0, 1'b1));
    stamp += 64'd1_000_000;
    send_stamp(make_word(stamp, SRC_ARRIVAL, 32'd0, 1'b1));
    send_stamp(make_word(stamp - 64'd500_000, SRC_ARRIVAL, 32'd0, 1'b1));
    stamp += 64'd1;
    send_stamp(make_word(stamp, SRC_ARRIVAL, 32'd0, 1'b1));
    stamp += 64'd100_000_001;
    send_stamp(make_word(stamp, SRC_ARRIVAL, 32'd0, 1'b1));
    stamp += 64'd100_000_000;
    send_stamp(make_word(stamp, SRC_ARRIVAL, 32'd0, 1'b1));
    stamp += 64'd1_000_000_001;
    send_stamp(make_word(stamp, SRC_ARRIVAL, 32'd0, 1'b1));
    stamp += 64'd1_000_000;
    send_stamp(make_word(stamp, SRC_ARRIVAL, 32'd25601, 1'b1));
    stamp += 64'd1_000_000;
    send_stamp(make_word(stamp, SRC_ARRIVAL, 32'd25600, 1'b1));
    stamp += 64'd1_000_000;
    send_stamp(make_word(stamp, SRC_ARRIVAL, 32'h8000_0000, 1'b1));
    stamp += 64'd1_000_000;
    send_stamp(make_word(stamp, SRC_ARRIVAL, 32'd0, 1'b0));
    stamp += 64'd1_000_000;
    send_stamp(make_word(stamp, SRC_ARRIVAL, -32'sd25600, 1'b1));
    stamp += 64'd1_000_000;
    send_stamp(make_word(stamp, 3'd7, 32'h7FFF_FFFF, 1'b0));
    send_stamp(make_word(stamp - 64'd7, SRC_SOFTWARE, 32'h7FFF_FFFF, 1'b1));
    drain_results();
    set_register(CFG_SOURCE, 48'd5);
    stamp += 64'd1_000_000;
    send_stamp(make_word(stamp, SRC_SOFTWARE, 32'd0, 1'b1));
    stamp += 64'd1_000_000;
    send_stamp(make_word(stamp, 3'd3, 32'd0, 1'b1));
    stamp += 64'd1_000_000;
    send_stamp(make_word(stamp, 3'd5, 32'd0, 1'b1));
    send_stamp(make_word(stamp - 64'd3, SRC_SOFTWARE, 32'h8000_0001, 1'b1));
  endtask

  task automatic test_rate_band();
    logic [63:0] stamp;
    drain_results();
    set_register(CFG_SOURCE, 48'(SRC_ARRIVAL));
    set_register(CFG_BAND_ENABLE, 48'd1);
    set_register(CFG_RATE_LOW, 48'd60_000_000);
    set_register(CFG_RATE_HIGH, 48'd70_000_000);
    stamp = {1'b0, seen_stamp};
    repeat (2) begin
      stamp += 64'd1_000_000;
      send_stamp(make_word(stamp, SRC_ARRIVAL, 32'd0, 1'b1));
    end
    repeat (2) begin
      stamp += 64'd300_000;
      send_stamp(make_word(stamp, SRC_ARRIVAL, 32'd0, 1'b1));
    end
    repeat (2) begin
      stamp += 64'd3_000_000;
      send_stamp(make_word(stamp, SRC_ARRIVAL, 32'd0, 1'b1));
    end
    drain_results();
    set_register(CFG_RATE_LOW, 48'hFFFF_FFFF);
    set_register(CFG_RATE_HIGH, 48'd0);
    stamp += 64'd1_000_000;
    send_stamp(make_word(stamp, SRC_ARRIVAL, 32'd0, 1'b1));
  endtask

  task automatic test_random_traffic();
    logic [63:0] nominal;
    logic [63:0] dropout;
    logic [63:0] failed;
    logic [63:0] low;
    logic [63:0] high;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain_results();
      nominal = 64'($urandom_range(200_000, 20_000_000));
      dropout = nominal * 64'($urandom_range(2, 6));
      failed = dropout * 64'($urandom_range(2, 4));
      low = NS_RATE_Q16 / (nominal + nominal / 4);
      high = NS_RATE_Q16 / (nominal - nominal / 4);
      case (phase)
        2: begin
          low = 64'hFFFF_FFFF;
          high = 64'd0;
        end
        3: begin
          dropout = 64'd0;
          failed = nominal * 4;
        end
        4: begin
          {low, high} = {high, low};
        end
        5: begin
          dropout = MAX48;
          failed = MAX48;
        end
        6: failed = 64'd0;
        7: begin
          low = 64'd0;
          high = 64'hFFFF_FFFF;
        end
        default: ;
      endcase
      set_register(CFG_DROPOUT_GAP, 48'(dropout));
      set_register(CFG_FAILED_GAP, 48'(failed));
      set_register(CFG_BAND_ENABLE, (phase % 4 != 1) ? 48'd1 : 48'd0);
      set_register(CFG_RATE_LOW, 48'(low));
      set_register(CFG_RATE_HIGH, 48'(high));
      set_register(CFG_SOURCE, 48'(phase));
      set_register(CFG_SKEW_LIMIT, phase == 3 ? 48'd0 :
                   phase == 6 ? 48'h7FFF_FFFF : 48'($urandom_range(1000, 60000)));
      if (phase == 7) set_register(CFG_UNUSED, {$urandom, 16'hBEEF});
      in_idle_pct = (phase == 2) ? 0 : 10;
      out_stall_pct = (phase == 2) ? 0 : 10;
      repeat (ITEMS_PER_PHASE) send_stamp(random_stamp(nominal));
    end
    in_idle_pct = 10;
    out_stall_pct = 10;
  endtask

  task automatic test_output_hold();
    drain_results();
    in_idle_pct = 0;
    hold_span = 600;
    hold_requests++;
    repeat (40) send_stamp(random_stamp(64'd1_000_000));
    in_idle_pct = 10;
  endtask

  task automatic test_edge_values();
    drain_results();
    set_register(CFG_DROPOUT_GAP, 48'd0);
    set_register(CFG_FAILED_GAP, 48'd0);
    send_stamp(make_word(MAX63 - 64'd5, SRC_SOFTWARE, 32'h7FFF_FFFF, 1'b1));
    send_stamp(make_word(MAX63, 3'd7, 32'h8000_0000, 1'b1));
    send_stamp(make_word(MAX63, 3'd7, 32'd0, 1'b0));
    drain_results();
    set_register(CFG_DROPOUT_GAP, MAX48);
    set_register(CFG_FAILED_GAP, MAX48);
    set_register(CFG_BAND_ENABLE, MAX48);
    set_register(CFG_RATE_LOW, MAX48);
    set_register(CFG_RATE_HIGH, MAX48);
    set_register(CFG_SOURCE, MAX48);
    set_register(CFG_SKEW_LIMIT, MAX48);
    repeat (EDGE_ITEMS) begin
      send_stamp(make_word({$urandom, $urandom}, 3'($urandom_range(7)), $urandom,
                           1'($urandom_range(1))));
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_word = '0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed_cases();
    test_rate_band();
    test_random_traffic();
    test_output_hold();
    test_edge_values();
    drain_results();
    $display("Covered %0d stamp words across %0d register writes: %0d clamped, %0d failed",
             words_sent, reg_writes, clamps, failed_levels);
    $display("Compared %0d health words field by field, %0d field errors",
             words_checked, mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/sshm_pkg.sv
hw/rtl/sshm_ctrl.sv
hw/rtl/sshm_datapath.sv
hw/rtl/sensor_stamp_health_monitor.sv
dv/sensor_stamp_health_monitor_tb.sv
